@@ hw/rtl/uer_pkg.sv @@
// Shared types, codes and constants of the ultrasonic echo ranger.
package uer_pkg;

	localparam int COUNTER_BITS_DEF = 16;
	localparam int PULSE_W          = 16;
	localparam int DIST_W           = 18;
	localparam int TRIG_W           = 8;
	localparam int CFG_IDX_W        = 3;
	localparam int CFG_DATA_W       = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NOISE_LIMIT_US = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_US     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Q16      = 3'd3;

	// register values after reset
	localparam logic [TRIG_W-1:0]  RST_TRIGGER_TICKS  = 8'd10;
	localparam logic [PULSE_W-1:0] RST_NOISE_LIMIT_US = 16'd150;
	localparam logic [PULSE_W-1:0] RST_TIMEOUT_US     = 16'd30000;
	localparam logic [PULSE_W-1:0] RST_SCALE_Q16      = 16'd1124;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_TRIG = 2'd1,
		PH_WAIT = 2'd2
	} phase_t;

	typedef struct packed {
		logic echo_level;
		logic start_request;
	} req_t;

	typedef struct packed {
		logic               trigger_level;
		logic               busy_res;
		logic               done_res;
		logic               timed_out;
		logic [PULSE_W-1:0] pulse_us;
		logic [DIST_W-1:0]  distance_q8;
	} res_t;

	typedef struct packed {
		logic [TRIG_W-1:0]  trigger_ticks;
		logic [PULSE_W-1:0] noise_limit_us;
		logic [PULSE_W-1:0] timeout_us;
		logic [PULSE_W-1:0] scale_q16;
	} cfg_t;

endpackage

@@ hw/rtl/uer_cfg.sv @@
// Configuration register file of the ultrasonic echo ranger.
module uer_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_valid,
	output logic                             wr_ready,
	input  logic [uer_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [uer_pkg::CFG_DATA_W-1:0]   wr_data,
	output uer_pkg::cfg_t                    cfg
);

	uer_pkg::cfg_t cfg_q;

	assign wr_ready = 1'b1;
	assign cfg      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trigger_ticks  <= uer_pkg::RST_TRIGGER_TICKS;
			cfg_q.noise_limit_us <= uer_pkg::RST_NOISE_LIMIT_US;
			cfg_q.timeout_us     <= uer_pkg::RST_TIMEOUT_US;
			cfg_q.scale_q16      <= uer_pkg::RST_SCALE_Q16;
		end else if (wr_valid && wr_ready) begin
			unique case (wr_index)
				uer_pkg::CFG_TRIGGER_TICKS: begin
					cfg_q.trigger_ticks <= wr_data[uer_pkg::TRIG_W-1:0];
				end
				uer_pkg::CFG_NOISE_LIMIT_US: begin
					cfg_q.noise_limit_us <= wr_data;
				end
				uer_pkg::CFG_TIMEOUT_US: begin
					cfg_q.timeout_us <= wr_data;
				end
				uer_pkg::CFG_SCALE_Q16: begin
					cfg_q.scale_q16 <= wr_data;
				end
				default: begin
					// drop writes to unmapped indexes
				end
			endcase
		end
	end

endmodule

@@ hw/rtl/uer_ctrl.sv @@
// Ranging state machine, echo pulse timing and distance scaling for one tick.
module uer_ctrl #(
	parameter int COUNTER_BITS = uer_pkg::COUNTER_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  uer_pkg::req_t req,
	input  uer_pkg::cfg_t cfg,
	output uer_pkg::res_t res
);

	localparam int CW = COUNTER_BITS;
	localparam int XW = (COUNTER_BITS > uer_pkg::PULSE_W) ? COUNTER_BITS : uer_pkg::PULSE_W;
	localparam int PW = 2 * uer_pkg::PULSE_W;
	localparam logic [CW-1:0] CNT_MAX = '1;

	uer_pkg::phase_t phase_q, phase_d;
	logic [CW-1:0]   wait_q, wait_d;
	logic [CW-1:0]   pcnt_q, pcnt_d;
	logic            open_q, open_d;
	logic            last_q;

	logic [uer_pkg::TRIG_W-1:0]  trig_len;
	logic [uer_pkg::PULSE_W-1:0] tmo_len;
	logic [CW-1:0]               wait_inc;
	logic [CW-1:0]               pcnt_inc;
	logic                        is_wait;
	logic                        is_trig;
	logic                        trig_hit;
	logic                        start_hit;
	logic                        rise;
	logic                        fall;
	logic                        done;
	logic                        tmo_hit;
	logic                        expire;
	logic [uer_pkg::PULSE_W-1:0] width;
	logic [PW-1:0]               product;

	// shared decode of the current tick
	always_comb begin
		trig_len  = (cfg.trigger_ticks == '0) ? uer_pkg::TRIG_W'(1) : cfg.trigger_ticks;
		tmo_len   = (cfg.timeout_us == '0) ? uer_pkg::PULSE_W'(1) : cfg.timeout_us;
		wait_inc  = (wait_q == CNT_MAX) ? wait_q : wait_q + CW'(1);
		pcnt_inc  = (pcnt_q == CNT_MAX) ? pcnt_q : pcnt_q + CW'(1);
		is_wait   = (phase_q == uer_pkg::PH_WAIT);
		is_trig   = (phase_q == uer_pkg::PH_TRIG);
		trig_hit  = XW'(wait_inc) >= XW'(trig_len);
		start_hit = (trig_len == uer_pkg::TRIG_W'(1));
		rise      = req.echo_level && !last_q;
		fall      = !req.echo_level && last_q && open_q;
		done      = is_wait && fall && (XW'(pcnt_q) > XW'(cfg.noise_limit_us));
		tmo_hit   = (XW'(wait_inc) >= XW'(tmo_len)) || (wait_inc == CNT_MAX);
		expire    = is_wait && !done && tmo_hit;
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		wait_d  = wait_q;
		pcnt_d  = pcnt_q;
		open_d  = open_q;
		unique case (phase_q)
			uer_pkg::PH_TRIG: begin
				if (trig_hit) begin
					phase_d = uer_pkg::PH_WAIT;
					wait_d  = '0;
				end else begin
					wait_d = wait_inc;
				end
			end
			uer_pkg::PH_WAIT: begin
				if (rise) begin
					open_d = 1'b1;
					pcnt_d = CW'(1);
				end else if (req.echo_level && open_q) begin
					pcnt_d = pcnt_inc;
				end else if (fall) begin
					open_d = 1'b0;
					pcnt_d = '0;
				end
				if (done) begin
					phase_d = uer_pkg::PH_IDLE;
					wait_d  = '0;
				end else if (tmo_hit) begin
					phase_d = uer_pkg::PH_IDLE;
					wait_d  = '0;
					open_d  = 1'b0;
					pcnt_d  = '0;
				end else begin
					wait_d = wait_inc;
				end
			end
			default: begin
				// idle, and any unused code behaves as idle
				phase_d = uer_pkg::PH_IDLE;
				if (req.start_request) begin
					open_d = 1'b0;
					pcnt_d = '0;
					if (start_hit) begin
						phase_d = uer_pkg::PH_WAIT;
						wait_d  = '0;
					end else begin
						phase_d = uer_pkg::PH_TRIG;
						wait_d  = CW'(1);
					end
				end
			end
		endcase
	end

	// result word
	always_comb begin
		if (done) begin
			width = (XW'(pcnt_q) > XW'(CNT_MAX) || XW'(pcnt_q) > XW'({uer_pkg::PULSE_W{1'b1}}))
				? {uer_pkg::PULSE_W{1'b1}} : uer_pkg::PULSE_W'(pcnt_q);
		end else begin
			width = '0;
		end
		product = PW'(width) * PW'(cfg.scale_q16);

		res.trigger_level = is_trig || (!is_wait && req.start_request);
		res.busy_res      = (phase_d != uer_pkg::PH_IDLE);
		res.done_res      = done;
		res.timed_out     = expire;
		res.pulse_us      = width;
		// saturate (width * scale) >> 8 at the top of the distance range
		res.distance_q8   = (|product[PW-1:uer_pkg::DIST_W+8]) ? {uer_pkg::DIST_W{1'b1}}
			: product[uer_pkg::DIST_W+7:8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= uer_pkg::PH_IDLE;
			wait_q  <= '0;
			pcnt_q  <= '0;
			open_q  <= 1'b0;
			last_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			wait_q  <= wait_d;
			pcnt_q  <= pcnt_d;
			open_q  <= open_d;
			last_q  <= req.echo_level;
		end
	end

	a_done_excl_tmo: assert property (@(posedge clk) disable iff (!arst_n)
		step |-> !(res.done_res && res.timed_out))
		else $error("done and timeout reported on one tick");

	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.done_res |=> phase_q == uer_pkg::PH_IDLE)
		else $error("measurement did not return to idle after done");

	a_open_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		open_q |-> phase_q == uer_pkg::PH_WAIT)
		else $error("echo pulse open outside the wait phase");

	a_trig_busy: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.trigger_level |-> res.busy_res)
		else $error("trigger driven without a measurement in progress");

endmodule

@@ hw/rtl/ultrasonic_echo_ranger.sv @@
// Top level of the ultrasonic echo ranger: input register, state logic, result register.
//
// Use: send one request word per microsecond tick on req (echo pin sample and a
// start request), handshake req_valid / req_stall. Every accepted word yields
// exactly one result word on res (trigger pin level, busy, done, timeout, echo
// width and distance in 1/256 cm), handshake res_valid / res_stall.
// Configuration registers (trigger length, noise limit, timeout, scale) are
// written on cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Write them only while no word is in flight.
// An accepted word is held in the input register and its result is registered in
// the result register, from which it is shown on res.
// Throughput: one word per cycle unless the receiver stalls; the whole tick update
// sits between the two registers, limited by the 16x16 distance multiplier.
// When the receiver stalls, the result register holds and the input register
// still takes one more word; req_stall rises only when both are full.
// Reset clears both valid flags, returns the state machine to idle with
// counters at zero, and loads the register defaults (10, 150, 30000, 1124).
module ultrasonic_echo_ranger #(
	parameter int COUNTER_BITS = uer_pkg::COUNTER_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  uer_pkg::req_t                  req,
	output logic                           res_valid,
	input  logic                           res_stall,
	output uer_pkg::res_t                  res,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_data
);

	uer_pkg::req_t req_s1;
	logic          req_valid_s1;
	uer_pkg::res_t res_s2;
	logic          res_valid_s2;
	uer_pkg::res_t res_next;
	uer_pkg::cfg_t cfg;
	logic          advance;
	logic          take_in;

	// move the held word forward when the result register is free or draining
	assign advance   = req_valid_s1 && (!res_valid_s2 || !res_stall);
	assign req_stall = req_valid_s1 && !advance;
	assign take_in   = req_valid && !req_stall;
	assign res_valid = res_valid_s2;
	assign res       = res_s2;

	uer_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cfg_valid),
		.wr_ready (cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	uer_ctrl #(
		.COUNTER_BITS (COUNTER_BITS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.req    (req_s1),
		.cfg    (cfg),
		.res    (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (take_in) begin
			req_valid_s1 <= 1'b1;
		end else if (advance) begin
			req_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			req_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= 1'b1;
		end else if (!res_stall) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench of the ultrasonic echo ranger: tick words against a per-tick model.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_CYCLES    = 80;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 6;
	localparam int FW             = uer_pkg::DIST_W;
	localparam logic [uer_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;
	localparam logic [uer_pkg::PULSE_W-1:0]   COUNT_TOP     = 16'hFFFF;
	localparam logic [uer_pkg::DIST_W-1:0]    DIST_TOP      = 18'h3FFFF;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           req_valid = 1'b0;
	logic                           req_stall;
	uer_pkg::req_t                  req       = '0;
	logic                           res_valid;
	logic                           res_stall = 1'b0;
	uer_pkg::res_t                  res;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [uer_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	uer_pkg::req_t tick_queue[$];   // tick words waiting to be sent
	uer_pkg::res_t echo_expect[$];  // predicted result words, oldest first

	// ranging model: register copy and measurement state
	uer_pkg::cfg_t               rng_cfg;
	uer_pkg::phase_t             rng_phase;
	logic [uer_pkg::PULSE_W-1:0] rng_wait;
	logic [uer_pkg::PULSE_W-1:0] rng_width;
	logic                        rng_open;
	logic                        rng_echo_prev;

	int send_gap_pct = 0;
	int recv_gap_pct = 0;
	int hold_from    = -1;
	int hold_left    = 0;
	bit hold_used    = 1'b0;
	int words_seen   = 0;
	int quiet_cycles = 0;
	int err_cnt      = 0;

	ultrasonic_echo_ranger dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic logic [uer_pkg::PULSE_W-1:0] count_up(logic [uer_pkg::PULSE_W-1:0] v);
		return (v == COUNT_TOP) ? v : v + uer_pkg::PULSE_W'(1);
	endfunction

	// advance the model by one tick and return the word the block should produce
	function automatic uer_pkg::res_t range_tick(uer_pkg::req_t w);
		uer_pkg::res_t               o;
		logic [uer_pkg::PULSE_W-1:0] trig_len;
		logic [uer_pkg::PULSE_W-1:0] tmo_len;
		logic [31:0]                 prod;
		o = '0;
		trig_len = (rng_cfg.trigger_ticks == '0) ? 16'd1
			: uer_pkg::PULSE_W'(rng_cfg.trigger_ticks);
		tmo_len  = (rng_cfg.timeout_us == '0) ? 16'd1 : rng_cfg.timeout_us;
		case (rng_phase)
		uer_pkg::PH_TRIG: begin
			o.trigger_level = 1'b1;
			rng_wait = count_up(rng_wait);
			if (rng_wait >= trig_len) begin
				rng_phase = uer_pkg::PH_WAIT;
				rng_wait = '0;
			end
		end
		uer_pkg::PH_WAIT: begin
			if (w.echo_level && !rng_echo_prev) begin
				rng_open = 1'b1;
				rng_width = 16'd1;
			end else if (w.echo_level && rng_open) begin
				rng_width = count_up(rng_width);
			end else if (!w.echo_level && rng_echo_prev && rng_open) begin
				rng_open = 1'b0;
				if (rng_width > rng_cfg.noise_limit_us) begin
					o.done_res = 1'b1;
					o.pulse_us = rng_width;
					prod = 32'(rng_width) * 32'(rng_cfg.scale_q16);
					o.distance_q8 = (|prod[31:26]) ? DIST_TOP : prod[25:8];
				end
				rng_width = '0;
			end
			// a finished pulse wins over an expiring wait
			if (o.done_res) begin
				rng_phase = uer_pkg::PH_IDLE;
				rng_wait = '0;
			end else begin
				rng_wait = count_up(rng_wait);
				if (rng_wait >= tmo_len || rng_wait == COUNT_TOP) begin
					o.timed_out = 1'b1;
					rng_phase = uer_pkg::PH_IDLE;
					rng_wait = '0;
					rng_open = 1'b0;
					rng_width = '0;
				end
			end
		end
		default: begin
			rng_phase = uer_pkg::PH_IDLE;
			if (w.start_request) begin
				o.trigger_level = 1'b1;
				rng_open = 1'b0;
				rng_width = '0;
				rng_wait = 16'd1;
				if (rng_wait >= trig_len) begin
					rng_phase = uer_pkg::PH_WAIT;
					rng_wait = '0;
				end else begin
					rng_phase = uer_pkg::PH_TRIG;
				end
			end
		end
		endcase
		rng_echo_prev = w.echo_level;
		o.busy_res = (rng_phase != uer_pkg::PH_IDLE);
		return o;
	endfunction

	function automatic void push_ticks(logic echo, logic start, int n);
		repeat (n) tick_queue.push_back('{echo_level: echo, start_request: start});
	endfunction

	// queue about n ticks of measurements shaped by the current register values
	function automatic void queue_ranging(int n);
		int goal;
		int trig_len;
		int tmo_len;
		int noise;
		int kind;
		int w;
		int gap;
		int i;
		goal     = tick_queue.size() + n;
		trig_len = (rng_cfg.trigger_ticks == '0) ? 1 : int'(rng_cfg.trigger_ticks);
		tmo_len  = (rng_cfg.timeout_us == '0) ? 1 : int'(rng_cfg.timeout_us);
		noise    = int'(rng_cfg.noise_limit_us);
		while (tick_queue.size() < goal) begin
			push_ticks(1'b0, 1'b0, $urandom_range(0, 3));
			push_ticks(1'($urandom_range(0, 1)), 1'b1, 1);
			for (i = 1; i < trig_len; i++)
				push_ticks($urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)), 1);
			kind = $urandom_range(0, 10);
			w = noise + 1 + $urandom_range(0, 3);
			if (w > tmo_len + 2)
				w = tmo_len + 2;
			gap = tmo_len - w - 1;
			if ((kind >= 6 && kind != 8 && kind != 10 && tmo_len > 500) ||
			    (kind == 8 && (gap < 0 || gap > 500)))
				kind = 0;
			case (kind)
			6, 7: begin
				for (i = 0; i <= tmo_len; i++)
					push_ticks($urandom_range(0, 3) == 0, 1'b0, 1);
			end
			8: begin
				// falling edge lands on the tick the wait expires
				push_ticks(1'b0, 1'b0, gap);
				push_ticks(1'b1, 1'b0, w);
				push_ticks(1'b0, 1'b0, 1);
			end
			9: begin
				push_ticks(1'b0, 1'b0, 1);
				push_ticks(1'b1, 1'b0, tmo_len);
			end
			10: begin
				for (i = $urandom_range(1, 30); i > 0; i--)
					push_ticks(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1);
			end
			default: begin
				if (noise > 0) begin
					repeat ($urandom_range(0, 2)) begin
						push_ticks(1'b0, 1'b0, $urandom_range(1, 3));
						push_ticks(1'b1, 1'b0, $urandom_range(1, (noise > 20) ? 20 : noise));
					end
				end
				push_ticks(1'b0, 1'b0, $urandom_range(1, 4));
				push_ticks(1'b1, 1'b0, w);
				push_ticks(1'b0, 1'b0, 1);
			end
			endcase
		end
	endfunction

	function automatic void check_field(string nm, logic [FW-1:0] e, logic [FW-1:0] a);
		if (a !== e) begin
			$display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, nm, e, a);
			err_cnt++;
		end
	endfunction

	task automatic write_reg(logic [uer_pkg::CFG_IDX_W-1:0] idx,
	                         logic [uer_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
		uer_pkg::CFG_TRIGGER_TICKS:  rng_cfg.trigger_ticks = val[uer_pkg::TRIG_W-1:0];
		uer_pkg::CFG_NOISE_LIMIT_US: rng_cfg.noise_limit_us = val;
		uer_pkg::CFG_TIMEOUT_US:     rng_cfg.timeout_us = val;
		uer_pkg::CFG_SCALE_Q16:      rng_cfg.scale_q16 = val;
		default: ;
		endcase
	endtask

	task automatic program_ranger(logic [uer_pkg::TRIG_W-1:0] trig,
	                              logic [uer_pkg::PULSE_W-1:0] noise,
	                              logic [uer_pkg::PULSE_W-1:0] tmo,
	                              logic [uer_pkg::PULSE_W-1:0] scale);
		// upper bits of the trigger word are don't-care
		write_reg(uer_pkg::CFG_TRIGGER_TICKS, {8'($urandom), trig});
		write_reg(uer_pkg::CFG_NOISE_LIMIT_US, noise);
		write_reg(uer_pkg::CFG_TIMEOUT_US, tmo);
		write_reg(uer_pkg::CFG_SCALE_Q16, scale);
	endtask

	// hold until everything sent has come back, then let the pipeline drain
	task automatic settle();
		do @(posedge clk); while (tick_queue.size() != 0 || req_valid || echo_expect.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			if (req_valid && !req_stall)
				echo_expect.push_back(range_tick(req));
			if (!req_valid || !req_stall) begin
				if (tick_queue.size() != 0 && int'($urandom_range(0, 99)) >= send_gap_pct) begin
					req <= tick_queue.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		uer_pkg::res_t want;
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				words_seen++;
				if (echo_expect.size() == 0) begin
					$display("%0t ns: result word with nothing predicted: %p", $time, res);
					err_cnt++;
				end else begin
					want = echo_expect.pop_front();
					check_field("trigger_level", FW'(want.trigger_level),
						FW'(res.trigger_level));
					check_field("busy_res", FW'(want.busy_res), FW'(res.busy_res));
					check_field("done_res", FW'(want.done_res), FW'(res.done_res));
					check_field("timed_out", FW'(want.timed_out), FW'(res.timed_out));
					check_field("pulse_us", FW'(want.pulse_us), FW'(res.pulse_us));
					check_field("distance_q8", want.distance_q8, res.distance_q8);
				end
			end
			if (hold_left > 0) begin
				hold_left--;
			end else if (!hold_used && words_seen == hold_from) begin
				hold_left = HOLD_CYCLES;
				hold_used = 1'b1;
			end
			res_stall <= (hold_left > 0) || (int'($urandom_range(0, 99)) < recv_gap_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (res_valid && !res_stall) ||
		    (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		rng_cfg = '{uer_pkg::RST_TRIGGER_TICKS, uer_pkg::RST_NOISE_LIMIT_US,
		            uer_pkg::RST_TIMEOUT_US, uer_pkg::RST_SCALE_Q16};
		rng_phase = uer_pkg::PH_IDLE;
		rng_wait = '0;
		rng_width = '0;
		rng_open = 1'b0;
		rng_echo_prev = 1'b0;
		send_gap_pct = 34;
		recv_gap_pct = 72;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: trigger of 2, noise limit 1, timeout 8, full scale
		program_ranger(8'd2, 16'd1, 16'd8, 16'hFFFF);
		push_ticks(1'b0, 1'b1, 1);
		push_ticks(1'b1, 1'b1, 1);  // start while busy, echo high as trigger ends
		push_ticks(1'b1, 1'b0, 1);  // already high at wait start: not measured
		push_ticks(1'b0, 1'b0, 1);  // falling edge with no open pulse
		push_ticks(1'b1, 1'b0, 1);
		push_ticks(1'b0, 1'b0, 1);  // width 1 is noise
		push_ticks(1'b1, 1'b0, 2);
		push_ticks(1'b0, 1'b0, 1);  // width 2 completes
		push_ticks(1'b1, 1'b1, 1);
		push_ticks(1'b1, 1'b0, 1);
		push_ticks(1'b0, 1'b0, 1);
		push_ticks(1'b1, 1'b0, 7);  // timeout with a pulse still open
		push_ticks(1'b0, 1'b1, 1);
		push_ticks(1'b0, 1'b0, 6);
		push_ticks(1'b1, 1'b0, 2);
		push_ticks(1'b0, 1'b0, 1);  // completion on the expiry tick
		settle();

		// zero trigger length and zero timeout behave as one
		program_ranger(8'd0, 16'd0, 16'd0, 16'($urandom));
		queue_ranging(30);
		settle();

		program_ranger(8'd1, 16'd0, 16'd40, 16'd0);
		write_reg(CFG_SPARE_IDX, 16'($urandom));
		queue_ranging(80);
		settle();

		send_gap_pct = 72;
		recv_gap_pct = 34;
		program_ranger(8'($urandom_range(1, 8)), 16'($urandom_range(0, 20)),
		               16'($urandom_range(30, 200)), 16'($urandom));
		hold_from = words_seen + 20;
		queue_ranging(80);
		settle();

		program_ranger(uer_pkg::RST_TRIGGER_TICKS, uer_pkg::RST_NOISE_LIMIT_US,
		               uer_pkg::RST_TIMEOUT_US, uer_pkg::RST_SCALE_Q16);
		queue_ranging(60);
		settle();

		// saturated distance from a pulse just over a high noise limit
		send_gap_pct = 0;
		recv_gap_pct = 0;
		program_ranger(8'd2, 16'd1024, 16'hFFFF, 16'hFFFF);
		push_ticks(1'b0, 1'b1, 1);
		push_ticks(1'b0, 1'b0, 1 + 3);
		push_ticks(1'b1, 1'b0, 1025);
		push_ticks(1'b0, 1'b0, 1);
		settle();

		// every pulse is noise
		program_ranger(8'd5, 16'hFFFF, 16'd100, 16'd300);
		queue_ranging(60);
		settle();

		if (err_cnt == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
